// ===== rtl/ecsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ecsm_pkg;
  localparam int FIELD_BITS  = 32;
  localparam int SCALAR_BITS = 32;
  localparam int SCNT_BITS   = $clog2(SCALAR_BITS + 1);
  localparam int FCNT_BITS   = $clog2(FIELD_BITS + 1);
  localparam logic [FIELD_BITS-1:0] PRIME_RESET = FIELD_BITS'(64'd4294967291);

  typedef logic [FIELD_BITS-1:0] fe_t;

  // Modular arithmetic unit opcodes
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_RED = 2'd3
  } mop_t;

  typedef struct packed {
    logic start;
    mop_t op;
  } mreq_t;
endpackage
`default_nettype wire

// ===== rtl/ecsm_modalu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared modular unit: add and subtract done the cycle after the request, multiply bit-serial
// (double-and-add, one multiplier bit a cycle), reduce by shift-subtract.
// req.start is a level held by the sequencer until done; ignore it in the done cycle.
module ecsm_modalu (
  input  wire                 clk,
  input  wire                 rst,
  input  ecsm_pkg::mreq_t     req,
  input  wire  ecsm_pkg::fe_t u,
  input  wire  ecsm_pkg::fe_t v,
  input  wire  ecsm_pkg::fe_t m,
  output logic                done,
  output ecsm_pkg::fe_t       res
);
  localparam int W = ecsm_pkg::FIELD_BITS;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_RED} st_t;
  st_t st;
  logic [W:0]   r;
  ecsm_pkg::fe_t mu;
  ecsm_pkg::fe_t mv;
  logic [ecsm_pkg::FCNT_BITS-1:0] cnt;

  logic [W:0] dbl, dblr, addu, addr_v, sum, diff;
  always_comb begin
    dbl    = {r[W-1:0], 1'b0};
    dblr   = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    addu   = dblr + {1'b0, mu};
    addr_v = (addu >= {1'b0, m}) ? addu - {1'b0, m} : addu;
    sum    = {1'b0, u} + {1'b0, v};
    diff   = (u >= v) ? {1'b0, u - v} : {1'b0, u} + {1'b0, m - v};
  end

  // Reduction: r holds partial remainder, shift in bits of mv from the top
  logic [W:0] rsh, rsub;
  always_comb begin
    rsh  = {r[W-1:0], mv[W-1]};
    rsub = (rsh >= {1'b0, m}) ? rsh - {1'b0, m} : rsh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: begin
          done <= req.start && !done &&
                  (req.op == ecsm_pkg::OP_ADD || req.op == ecsm_pkg::OP_SUB);
          if (req.start && !done) begin
            unique case (req.op)
              ecsm_pkg::OP_ADD: begin
                res <= (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : W'(sum);
              end
              ecsm_pkg::OP_SUB: begin
                res <= W'(diff);
              end
              ecsm_pkg::OP_MUL: begin
                r   <= '0;
                mu  <= u;
                mv  <= v;
                cnt <= '0;
                st  <= S_MUL;
              end
              ecsm_pkg::OP_RED: begin
                r   <= '0;
                mv  <= u;
                cnt <= '0;
                st  <= S_RED;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          r    <= mv[W-1] ? addr_v : dblr;
          mv   <= {mv[W-2:0], 1'b0};
          cnt  <= cnt + 1'b1;
          done <= (cnt == ecsm_pkg::FCNT_BITS'(W - 1));
          if (cnt == ecsm_pkg::FCNT_BITS'(W - 1)) begin
            res <= mv[W-1] ? W'(addr_v) : W'(dblr);
            st  <= S_IDLE;
          end
        end
        S_RED: begin
          r    <= rsub;
          mv   <= {mv[W-2:0], 1'b0};
          cnt  <= cnt + 1'b1;
          done <= (cnt == ecsm_pkg::FCNT_BITS'(W - 1));
          if (cnt == ecsm_pkg::FCNT_BITS'(W - 1)) begin
            res <= W'(rsub);
            st  <= S_IDLE;
          end
        end
        default: begin
          done <= 1'b0;
          st   <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (st == S_MUL) |=> (st == S_MUL || done))
    else $error("multiply left without done");
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    (done && m >= 3) |-> (res < m))
    else $error("result not reduced");
`endif
endmodule
`default_nettype wire

// ===== rtl/ec_point_scalar_multiply.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Per scalar bit one doubling and at most one addition, each needing a Fermat
// inversion of up to 62 bit-serial multiplies plus further ALU operations.
// Throughput: one transaction at a time; in_ready is low while busy, and a finished
// result waits in the output register without holding off the next accept.
// Reset: synchronous; field_prime returns to 2^32-5, curve_a to 0, sequencer idles.
module ec_point_scalar_multiply (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [31:0] base_x,
  input  wire  [31:0] base_y,
  input  wire  [31:0] scalar,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] result_x,
  output logic [31:0] result_y
);
  localparam int W  = ecsm_pkg::FIELD_BITS;
  localparam int K  = ecsm_pkg::SCALAR_BITS;
  localparam int KI = $clog2(K);
  localparam logic [0:0] REG_PRIME = 1'b0;
  localparam logic [0:0] REG_A     = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE, S_RA, S_RX, S_RY, S_BIT, S_DBL,
    D0, D1, D2, D3, D4, D5, DINV, D6, D7, D8, D9, D10, D11, D12,
    S_ADD, A0, A1, AINV, A2, A3, A4, A5, A6, A7, A8,
    I_LOOP, I_SQ, S_NEXT, S_OUT
  } st_t;

  st_t st, ret;
  ecsm_pkg::fe_t prime, ca;
  ecsm_pkg::fe_t m, a, bx, by, ax, ay, s, t, n;
  logic [K-1:0] k;
  logic [ecsm_pkg::SCNT_BITS-1:0] bitc;
  ecsm_pkg::fe_t e, ir, ib;
  logic dbl_from_add;
  logic [31:0] rx, ry;

  ecsm_pkg::mreq_t req;
  ecsm_pkg::mop_t  alu_op;
  ecsm_pkg::fe_t   u, v, res;
  logic            done, wait_alu;

  ecsm_modalu u_alu (
    .clk(clk), .rst(rst), .req(req), .u(u), .v(v), .m(m), .done(done), .res(res)
  );

  assign req      = '{wait_alu, alu_op};
  assign in_ready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= ecsm_pkg::PRIME_RESET;
      ca    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRIME: prime <= W'(cfg_data);
        REG_A:     ca    <= W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Issue one ALU op and mark the wait; the result lands in res when done
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      wait_alu  <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (wait_alu) begin
        if (done) wait_alu <= 1'b0;
      end else begin
        unique case (st)
          S_IDLE: if (in_valid && in_ready) begin
            m  <= prime; k <= scalar; ax <= '0; ay <= '0;
            bx <= base_x; by <= base_y;
            bitc <= ecsm_pkg::SCNT_BITS'(K);
            if (prime < 3) begin
              rx <= '0; ry <= '0; st <= S_OUT;
            end else begin
              u <= ca; alu_op <= ecsm_pkg::OP_RED; wait_alu <= 1'b1; st <= S_RA;
            end
          end
          S_RA: begin
            a <= res; u <= bx; alu_op <= ecsm_pkg::OP_RED; wait_alu <= 1'b1;
            st <= S_RX;
          end
          S_RX: begin
            bx <= res; u <= by; alu_op <= ecsm_pkg::OP_RED; wait_alu <= 1'b1;
            st <= S_RY;
          end
          S_RY: begin by <= res; st <= S_BIT; end
          S_BIT: begin
            if (bitc == 0) begin
              rx <= ax; ry <= ay; st <= S_OUT;
            end else begin
              dbl_from_add <= 1'b0; st <= S_DBL;
            end
          end
          // ---- doubling of (ax, ay)
          S_DBL: begin
            if (ay == '0) begin
              ax <= '0; ay <= '0; st <= dbl_from_add ? S_NEXT : S_ADD;
            end else begin
              u <= ax; v <= ax; alu_op <= ecsm_pkg::OP_MUL; wait_alu <= 1'b1;
              st <= D0;
            end
          end
          D0: begin n <= res; u <= res; v <= res;
            alu_op <= ecsm_pkg::OP_ADD; wait_alu <= 1'b1; st <= D1; end
          D1: begin u <= res; v <= n;
            alu_op <= ecsm_pkg::OP_ADD; wait_alu <= 1'b1; st <= D2; end
          D2: begin u <= res; v <= a;
            alu_op <= ecsm_pkg::OP_ADD; wait_alu <= 1'b1; st <= D3; end
          D3: begin n <= res; u <= ay; v <= ay;
            alu_op <= ecsm_pkg::OP_ADD; wait_alu <= 1'b1; st <= D4; end
          D4: begin
            ib <= res; ir <= W'(1); e <= m - W'(2); ret <= D5; st <= I_LOOP;
          end
          D5: begin u <= n; v <= ir;
            alu_op <= ecsm_pkg::OP_MUL; wait_alu <= 1'b1; st <= DINV; end
          DINV: begin s <= res; u <= res; v <= res;
            alu_op <= ecsm_pkg::OP_MUL; wait_alu <= 1'b1; st <= D6; end
          D6: begin t <= res; u <= ax; v <= ax;
            alu_op <= ecsm_pkg::OP_ADD; wait_alu <= 1'b1; st <= D7; end
          D7: begin u <= t; v <= res;
            alu_op <= ecsm_pkg::OP_SUB; wait_alu <= 1'b1; st <= D8; end
          D8: begin t <= res; u <= ax; v <= res;
            alu_op <= ecsm_pkg::OP_SUB; wait_alu <= 1'b1; st <= D9; end
          D9: begin u <= s; v <= res;
            alu_op <= ecsm_pkg::OP_MUL; wait_alu <= 1'b1; st <= D10; end
          D10: begin u <= res; v <= ay;
            alu_op <= ecsm_pkg::OP_SUB; wait_alu <= 1'b1; st <= D11; end
          D11: begin ay <= res; ax <= t; st <= D12; end
          D12: st <= dbl_from_add ? S_NEXT : S_ADD;
          // ---- conditional add of base
          S_ADD: begin
            if (!k[KI'(bitc - 1'b1)]) st <= S_NEXT;
            else if (bx == '0 && by == '0) st <= S_NEXT;
            else if (ax == '0 && ay == '0) begin ax <= bx; ay <= by; st <= S_NEXT; end
            else if (ax == bx) begin
              if (ay == by) begin dbl_from_add <= 1'b1; st <= S_DBL; end
              else begin ax <= '0; ay <= '0; st <= S_NEXT; end
            end else begin
              u <= ay; v <= by; alu_op <= ecsm_pkg::OP_SUB; wait_alu <= 1'b1;
              st <= A0;
            end
          end
          A0: begin n <= res; u <= ax; v <= bx;
            alu_op <= ecsm_pkg::OP_SUB; wait_alu <= 1'b1; st <= A1; end
          A1: begin ib <= res; ir <= W'(1); e <= m - W'(2); ret <= AINV; st <= I_LOOP; end
          AINV: begin u <= n; v <= ir;
            alu_op <= ecsm_pkg::OP_MUL; wait_alu <= 1'b1; st <= A2; end
          A2: begin s <= res; u <= res; v <= res;
            alu_op <= ecsm_pkg::OP_MUL; wait_alu <= 1'b1; st <= A3; end
          A3: begin u <= res; v <= ax;
            alu_op <= ecsm_pkg::OP_SUB; wait_alu <= 1'b1; st <= A4; end
          A4: begin u <= res; v <= bx;
            alu_op <= ecsm_pkg::OP_SUB; wait_alu <= 1'b1; st <= A5; end
          A5: begin t <= res; u <= ax; v <= res;
            alu_op <= ecsm_pkg::OP_SUB; wait_alu <= 1'b1; st <= A6; end
          A6: begin u <= s; v <= res;
            alu_op <= ecsm_pkg::OP_MUL; wait_alu <= 1'b1; st <= A7; end
          A7: begin u <= res; v <= ay;
            alu_op <= ecsm_pkg::OP_SUB; wait_alu <= 1'b1; st <= A8; end
          A8: begin ay <= res; ax <= t; st <= S_NEXT; end
          // ---- Fermat inverse: ir = ib^e by right-to-left square-and-multiply
          I_LOOP: begin
            if (e == '0) st <= ret;
            else if (e[0]) begin
              u <= ir; v <= ib; alu_op <= ecsm_pkg::OP_MUL; wait_alu <= 1'b1;
              st <= I_SQ;
            end else begin
              u <= ib; v <= ib; alu_op <= ecsm_pkg::OP_MUL; wait_alu <= 1'b1;
              st <= I_SQ;
            end
          end
          I_SQ: begin
            // odd e: res is ir*ib, square still owed; even e: res is ib*ib
            if (e[0]) begin
              ir <= res; e <= e & ~W'(1);
              st <= I_LOOP;
            end else begin
              ib <= res; e <= e >> 1; st <= I_LOOP;
            end
          end
          S_NEXT: begin bitc <= bitc - 1'b1; st <= S_BIT; end
          S_OUT: if (!out_valid) begin
            result_x <= rx; result_y <= ry; out_valid <= 1'b1; st <= S_IDLE;
          end
          default: st <= S_IDLE;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (st != S_IDLE) |-> !in_ready)
    else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_x) && $stable(result_y)))
    else $error("result dropped while stalled");
  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && scalar == '0 && prime >= 3) |=> (ax == '0 && ay == '0))
    else $error("accumulator not cleared");
`endif
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  localparam logic [0:0] CFG_PRIME = 1'b0;
  localparam logic [0:0] CFG_CURVE_A = 1'b1;
  localparam int IDLE_LIMIT = 2000000;
  localparam int LONG_HOLD = 3000;

  typedef struct {
    logic [63:0] x;
    logic [63:0] y;
  } ec_pt_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
  } point_out_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] k;
    bit typed;
    logic [31:0] ex;
    logic [31:0] ey;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] base_x = '0;
  logic [31:0] base_y = '0;
  logic [31:0] scalar = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] result_x;
  logic [31:0] result_y;

  logic [63:0] prime_mirror = 64'd4294967291;
  logic [63:0] curve_a_mirror = 64'd0;
  point_out_t expected_points[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit long_hold_req = 1'b0;

  ec_point_scalar_multiply i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .base_x(base_x), .base_y(base_y), .scalar(scalar),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_x(result_x), .result_y(result_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] mod_add(logic [63:0] u, logic [63:0] v, logic [63:0] m);
    logic [63:0] s;
    s = u + v;
    if (s >= m) s = s - m;
    return s;
  endfunction

  function automatic logic [63:0] mod_sub(logic [63:0] u, logic [63:0] v, logic [63:0] m);
    return (u >= v) ? (u - v) : (u + (m - v));
  endfunction

  function automatic logic [63:0] mod_mul(logic [63:0] u, logic [63:0] v, logic [63:0] m);
    return (u * v) % m;
  endfunction

  // Fermat inverse: n^(m-2), applied even when m is not prime
  function automatic logic [63:0] mod_inv(logic [63:0] n, logic [63:0] m);
    logic [63:0] e, r, b;
    e = m - 2;
    r = 1 % m;
    b = n;
    while (e != 0) begin
      if (e[0]) r = mod_mul(r, b, m);
      b = mod_mul(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic ec_pt_t pt_double(ec_pt_t q, logic [63:0] a, logic [63:0] m);
    ec_pt_t r;
    logic [63:0] num, slope, t;
    r.x = 0;
    r.y = 0;
    if (q.y == 0) return r;
    num = mod_mul(q.x, q.x, m);
    num = mod_add(mod_add(num, num, m), num, m);
    num = mod_add(num, a, m);
    slope = mod_mul(num, mod_inv(mod_add(q.y, q.y, m), m), m);
    t = mod_sub(mod_mul(slope, slope, m), mod_add(q.x, q.x, m), m);
    r.x = t;
    r.y = mod_sub(mod_mul(slope, mod_sub(q.x, t, m), m), q.y, m);
    return r;
  endfunction

  function automatic ec_pt_t pt_add(ec_pt_t p1, ec_pt_t p2, logic [63:0] a, logic [63:0] m);
    ec_pt_t r;
    logic [63:0] slope, t;
    r.x = 0;
    r.y = 0;
    if (p1.x == 0 && p1.y == 0) return p2;
    if (p2.x == 0 && p2.y == 0) return p1;
    if (p1.x == p2.x) begin
      if (p1.y == p2.y) return pt_double(p1, a, m);
      return r;
    end
    slope = mod_mul(mod_sub(p1.y, p2.y, m), mod_inv(mod_sub(p1.x, p2.x, m), m), m);
    t = mod_sub(mod_sub(mod_mul(slope, slope, m), p1.x, m), p2.x, m);
    r.x = t;
    r.y = mod_sub(mod_mul(slope, mod_sub(p1.x, t, m), m), p1.y, m);
    return r;
  endfunction

  function automatic point_out_t scalar_mult(logic [31:0] x, logic [31:0] y, logic [31:0] k);
    ec_pt_t acc, base;
    point_out_t res;
    logic [63:0] m, a;
    m = prime_mirror;
    acc.x = 0;
    acc.y = 0;
    if (m >= 3) begin
      a = curve_a_mirror % m;
      base.x = {32'd0, x} % m;
      base.y = {32'd0, y} % m;
      for (int i = ecsm_pkg::SCALAR_BITS - 1; i >= 0; i--) begin
        acc = pt_double(acc, a, m);
        if (k[i]) acc = pt_add(acc, base, a, m);
      end
    end
    res.x = acc.x[31:0];
    res.y = acc.y[31:0];
    return res;
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PRIME) prime_mirror = {32'd0, value};
    else curve_a_mirror = {32'd0, value};
  endtask

  task automatic drain();
    while (expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] k,
                            bit typed, point_out_t typed_val);
    int gap;
    point_out_t exp_pt;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    base_x <= x;
    base_y <= y;
    scalar <= k;
    do @(posedge clk); while (!in_ready);
    exp_pt = typed ? typed_val : scalar_mult(x, y, k);
    expected_points.insert(expected_points.size(), exp_pt);
    items_sent++;
  endtask

  // fast: scalars of 0 or 1 only
  task automatic random_items(int count, bit fast);
    logic [31:0] x, y, k;
    point_out_t none;
    none.x = 0;
    none.y = 0;
    repeat (count) begin
      if ($urandom_range(0, 1) == 0 && prime_mirror > 2 && prime_mirror < 65536) begin
        x = $urandom_range(0, prime_mirror - 1);
        y = $urandom_range(0, prime_mirror - 1);
      end else begin
        x = $urandom();
        y = $urandom();
      end
      if ($urandom_range(0, 15) == 0) y = 0;
      if (fast) begin
        k = $urandom_range(0, 1);
      end else begin
        case ($urandom_range(0, 3))
          0: k = $urandom();
          1: k = $urandom_range(0, 3);
          default: k = $urandom_range(0, 300);
        endcase
      end
      send_point(x, y, k, 1'b0, none);
    end
  endtask

  // sink side: random stalls, one long hold on request
  initial begin
    int stall;
    bit long_hold_done;
    long_hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (long_hold_req && !long_hold_done) begin
        stall = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("Timeout after %0d idle cycles", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result x=%h y=%h", result_x, result_y);
        end else begin
          point_out_t e;
          e = expected_points.pop_front();
          if (e.x !== result_x || e.y !== result_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result mismatch: expected (%h,%h) got (%h,%h)",
                       e.x, e.y, result_x, result_y);
          end
        end
      end
    end
  end

  initial begin
    dir_row_t rows[13];
    point_out_t tv;
    logic [31:0] phase_prime[8];
    logic [31:0] phase_a[8];

    rows[0]  = '{32'd0, 32'd0, 32'd5, 1'b1, 32'd0, 32'd0};
    rows[1]  = '{32'd7, 32'd9, 32'd0, 1'b1, 32'd0, 32'd0};
    rows[2]  = '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'd1, 1'b1, 32'd4, 32'd3};
    rows[3]  = '{32'd5, 32'd0, 32'd2, 1'b1, 32'd0, 32'd0};
    rows[4]  = '{32'hFFFFFFFB, 32'd1, 32'd1, 1'b1, 32'd0, 32'd1};
    rows[5]  = '{32'hFFFFFFFB, 32'hFFFFFFFB, 32'd1, 1'b1, 32'd0, 32'd0};
    rows[6]  = '{32'd0, 32'd0, 32'hFFFFFFFF, 1'b1, 32'd0, 32'd0};
    rows[7]  = '{32'd5, 32'd0, 32'd3, 1'b0, 32'd0, 32'd0};
    rows[8]  = '{32'd3, 32'd4, 32'd2, 1'b0, 32'd0, 32'd0};
    rows[9]  = '{32'd3, 32'd4, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0};
    rows[10] = '{32'd1, 32'd1, 32'h80000000, 1'b0, 32'd0, 32'd0};
    rows[11] = '{32'h12345678, 32'h9ABCDEF0, 32'h0000FFFF, 1'b0, 32'd0, 32'd0};
    rows[12] = '{32'hAAAAAAAA, 32'h55555555, 32'd7, 1'b0, 32'd0, 32'd0};

    phase_prime = '{32'd97, 32'd5, 32'd3, 32'hFFFFFFFF, 32'd2, 32'd0,
                    32'd65537, 32'd4294967291};
    phase_a = '{32'd2, 32'd4, 32'd0, 32'hFFFFFFFF, 32'd1, 32'd7,
                32'd12345, 32'd0};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      tv.x = rows[i].ex;
      tv.y = rows[i].ey;
      send_point(rows[i].x, rows[i].y, rows[i].k, rows[i].typed, tv);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    drain();

    // back up the block: hold the sink while the source keeps offering
    long_hold_req = 1'b1;
    random_items(5, 1'b1);
    @(negedge clk);
    in_valid <= 1'b0;
    drain();

    foreach (phase_prime[i]) begin
      write_reg(CFG_PRIME, phase_prime[i]);
      write_reg(CFG_CURVE_A, i == 7 ? $urandom() : phase_a[i]);
      random_items(11, 1'b0);
      @(negedge clk);
      in_valid <= 1'b0;
      drain();
    end

    repeat (50) @(posedge clk);
    $display("Ran %0d points (%0d results) over 9 prime/a settings incl. degenerate moduli",
             items_sent, results_seen);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_points.size());
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
